// ===== hdl/mono_bitmap_rop_blitter_core_defines.svh =====
// Assertion macros shared by the blitter RTL.
// Depends on nothing; the files that assert include it by name.
`ifndef MONO_BITMAP_ROP_BLITTER_CORE_DEFINES_SVH
`define MONO_BITMAP_ROP_BLITTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MBRB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MBRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mbrb_pkg.sv =====
// Shared types, constants and helpers of the 1bpp raster-operation blitter.
// No dependencies; used by every module of the block.
package mbrb_pkg;

    localparam int MEM_BYTES = 16384;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int PIX_AW    = MEM_AW + 3;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 40;

    // operation codes
    localparam logic [1:0] OP_LOAD_SRC = 2'd0;
    localparam logic [1:0] OP_LOAD_DST = 2'd1;
    localparam logic [1:0] OP_BLIT     = 2'd2;
    localparam logic [1:0] OP_READ_DST = 2'd3;

    // configuration register indexes
    localparam logic CFG_DEST_WIDTH  = 1'b0;
    localparam logic CFG_DEST_HEIGHT = 1'b1;

    // classified request handed from front to back
    typedef struct packed {
        logic [1:0]        operation;
        logic [MEM_AW-1:0] byte_addr;
        logic [7:0]        byte_data;
        logic [11:0]       src_pitch;
        logic [11:0]       src_x;
        logic [11:0]       src_y;
        logic [11:0]       start_x;
        logic [11:0]       start_y;
        logic [12:0]       ncols;
        logic [12:0]       nrows;
        logic [3:0]        raster_op;
        logic              empty;
        logic [24:0]       pixels_done;
    } cmd_t;

    // new pixel: bit (3 - 2s - d) of the raster operation
    function automatic logic rop_apply(input logic [3:0] rop, input logic s, input logic d);
        logic [1:0] sel;
        sel = ~{s, d};
        return rop[sel];
    endfunction

endpackage

// ===== hdl/mbrb_front.sv =====
// Front end: holds the configuration, takes requests, clips blits and sizes them.
// Depends on mbrb_pkg.
module mbrb_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [11:0]                    cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mbrb_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]                     s_tuser,
    output logic [11:0]                    dest_width,
    output logic                           q_valid,
    input  logic                           q_ready,
    output mbrb_pkg::cmd_t                 q_data
);
    import mbrb_pkg::*;

    logic [11:0] dw_reg, dh_reg;
    logic        fv_reg;
    cmd_t        cmd_reg, cmd_next;

    logic [12:0] xe, ye, xe_c, ye_c, ncols, nrows;
    logic [11:0] x0, y0;
    logic        empty;
    logic [25:0] area;

    assign cfg_ready  = 1'b1;
    assign dest_width = dw_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dw_reg <= 12'd240;
            dh_reg <= 12'd320;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DEST_WIDTH:  dw_reg <= cfg_data;
                CFG_DEST_HEIGHT: dh_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clip and size the rectangle
    always_comb begin
        x0    = s_tdata[69:58];
        y0    = s_tdata[81:70];
        xe    = s_tdata[94:82];
        ye    = s_tdata[107:95];
        xe_c  = (xe > {1'b0, dw_reg}) ? {1'b0, dw_reg} : xe;
        ye_c  = (ye > {1'b0, dh_reg}) ? {1'b0, dh_reg} : ye;
        empty = ({1'b0, x0} >= xe_c) || ({1'b0, y0} >= ye_c);
        ncols = xe_c - {1'b0, x0};
        nrows = ye_c - {1'b0, y0};
        area  = ncols * nrows;
        cmd_next.operation   = s_tuser;
        cmd_next.byte_addr   = s_tdata[13:0];
        cmd_next.byte_data   = s_tdata[21:14];
        cmd_next.src_pitch   = s_tdata[33:22];
        cmd_next.src_x       = s_tdata[45:34];
        cmd_next.src_y       = s_tdata[57:46];
        cmd_next.start_x     = x0;
        cmd_next.start_y     = y0;
        cmd_next.ncols       = ncols;
        cmd_next.nrows       = nrows;
        cmd_next.raster_op   = s_tdata[111:108];
        cmd_next.empty       = empty;
        cmd_next.pixels_done = empty ? 25'd0 : area[24:0];
    end

    // one request register in front of the queue
    assign s_tready = !fv_reg || q_ready;
    assign q_valid  = fv_reg;
    assign q_data   = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (s_tready) begin
            fv_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ===== hdl/mbrb_cmd_queue.sv =====
// Two-entry request queue between front end and blit engine.
// Depends on mbrb_pkg for the request type.
module mbrb_cmd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  mbrb_pkg::cmd_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output mbrb_pkg::cmd_t rd_data
);
    import mbrb_pkg::*;

    cmd_t       slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = slot_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wp_reg] <= wr_data;
    end

endmodule

// ===== hdl/mbrb_engine.sv =====
// Back end: both bitmap memories, the per-pixel read-modify-write walk, result register.
// Depends on mbrb_pkg and the assertion macros header.
`include "mono_bitmap_rop_blitter_core_defines.svh"
module mbrb_engine (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [11:0]                    dest_width,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  mbrb_pkg::cmd_t                 q_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mbrb_pkg::M_TDATA_W-1:0] m_tdata
);
    import mbrb_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_SETUP = 3'd2;
    localparam logic [2:0] ST_ROW   = 3'd3;
    localparam logic [2:0] ST_PRD   = 3'd4;
    localparam logic [2:0] ST_PWR   = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    logic [7:0] src_mem [MEM_BYTES];
    logic [7:0] dst_mem [MEM_BYTES];

    logic [2:0]        state_reg, state_next;
    cmd_t              cmd_reg;
    logic [PIX_AW-1:0] drow_reg, srow_reg, dptr_reg, sptr_reg;
    logic [12:0]       cols_reg, rows_reg;
    logic [7:0]        sq_reg, dq_reg;
    logic              mv_reg;
    logic [M_TDATA_W-1:0] mdata_reg;

    logic [23:0]       dprod, sprod;
    logic [MEM_AW-1:0] drd_addr, dwr_addr;
    logic              dwr_en;
    logic [7:0]        dwr_data, newbyte;
    logic              pix_s, pix_d, pix_r;
    logic              out_free;

    assign q_ready  = (state_reg == ST_IDLE);
    assign out_free = !mv_reg || m_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;

    // pixel update
    always_comb begin
        pix_s   = sq_reg[sptr_reg[2:0]];
        pix_d   = dq_reg[dptr_reg[2:0]];
        pix_r   = rop_apply(cmd_reg.raster_op, pix_s, pix_d);
        newbyte = dq_reg;
        newbyte[dptr_reg[2:0]] = pix_r;
        dprod   = cmd_reg.start_y * dest_width;
        sprod   = cmd_reg.src_y * cmd_reg.src_pitch;
    end

    // destination port selection
    always_comb begin
        drd_addr = (state_reg == ST_PRD) ? dptr_reg[PIX_AW-1:3] : cmd_reg.byte_addr;
        dwr_en   = 1'b0;
        dwr_addr = cmd_reg.byte_addr;
        dwr_data = cmd_reg.byte_data;
        if (state_reg == ST_EXEC && cmd_reg.operation == OP_LOAD_DST) begin
            dwr_en = 1'b1;
        end else if (state_reg == ST_PWR) begin
            dwr_en   = 1'b1;
            dwr_addr = dptr_reg[PIX_AW-1:3];
            dwr_data = newbyte;
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXEC && cmd_reg.operation == OP_LOAD_SRC) begin
            src_mem[cmd_reg.byte_addr] <= cmd_reg.byte_data;
        end
        sq_reg <= src_mem[sptr_reg[PIX_AW-1:3]];
    end

    always_ff @(posedge aclk) begin
        if (dwr_en) dst_mem[dwr_addr] <= dwr_data;
        dq_reg <= dst_mem[drd_addr];
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_valid) state_next = ST_EXEC;
            ST_EXEC: begin
                if (cmd_reg.operation == OP_BLIT && !cmd_reg.empty) state_next = ST_SETUP;
                else state_next = ST_FIN;
            end
            ST_SETUP: state_next = ST_ROW;
            ST_ROW:   state_next = ST_PRD;
            ST_PRD:   state_next = ST_PWR;
            ST_PWR: begin
                if (cols_reg != 13'd1)      state_next = ST_PRD;
                else if (rows_reg != 13'd1) state_next = ST_ROW;
                else                        state_next = ST_FIN;
            end
            ST_FIN:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // walk counters and row bases
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: if (q_valid) cmd_reg <= q_data;
            ST_SETUP: begin
                drow_reg <= dprod[PIX_AW-1:0];
                srow_reg <= sprod[PIX_AW-1:0] + {{(PIX_AW-12){1'b0}}, cmd_reg.src_x};
                rows_reg <= cmd_reg.nrows;
            end
            ST_ROW: begin
                dptr_reg <= drow_reg + {{(PIX_AW-12){1'b0}}, cmd_reg.start_x};
                sptr_reg <= srow_reg;
                cols_reg <= cmd_reg.ncols;
            end
            ST_PWR: begin
                dptr_reg <= dptr_reg + PIX_AW'(1);
                sptr_reg <= sptr_reg + PIX_AW'(1);
                cols_reg <= cols_reg - 13'd1;
                if (cols_reg == 13'd1) begin
                    rows_reg <= rows_reg - 13'd1;
                    drow_reg <= drow_reg + {{(PIX_AW-12){1'b0}}, dest_width};
                    srow_reg <= srow_reg + {{(PIX_AW-12){1'b0}}, cmd_reg.src_pitch};
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (state_reg == ST_FIN && out_free) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && out_free) begin
            mdata_reg[7:0]  <= (cmd_reg.operation == OP_READ_DST) ? dq_reg : 8'd0;
            mdata_reg[32:8] <= (cmd_reg.operation == OP_BLIT) ? cmd_reg.pixels_done : 25'd0;
            mdata_reg[M_TDATA_W-1:33] <= '0;
        end
    end

    `MBRB_ASSERT_NOW(a_pwr_after_prd, state_reg == ST_PWR, $past(state_reg) == ST_PRD, "write without read")
    `MBRB_ASSERT_NOW(a_pop_idle, q_valid && q_ready, state_reg == ST_IDLE, "request taken while busy")
    `MBRB_ASSERT_NEXT(a_fin_result, state_reg == ST_FIN && out_free, mv_reg && state_reg == ST_IDLE, "result lost")

endmodule

// ===== hdl/mono_bitmap_rop_blitter_core.sv =====
// Top level of the 1bpp bitmap blitter with 16 raster operations.
// Depends on mbrb_pkg, mbrb_front, mbrb_cmd_queue and mbrb_engine.
//
//  channel  dir  payload
//  s_       in   tuser: operation; tdata: address, data, blit geometry, raster op
//  m_       out  tdata: read_data, pixels_done
//  cfg_     in   index 0 dest_width, 1 dest_height
//
// A blit walks its rectangle row by row as a pixel read-modify-write loop
// in the engine: read the destination byte, then write the updated byte.
// aresetn is synchronous, active low; memories are not cleared.
// While they have room, the front end and queue keep taking requests while the
// engine works or the result waits; m_tvalid holds until m_tready.
module mono_bitmap_rop_blitter_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [11:0]                    cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [13:0] byte_addr, [21:14] byte_data, [33:22] src_pitch, [45:34] src_x,
    // [57:46] src_y, [69:58] start_x, [81:70] start_y, [94:82] end_x,
    // [107:95] end_y, [111:108] raster_op
    input  logic [mbrb_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]                     s_tuser,   // [1:0] operation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] read_data, [32:8] pixels_done, [39:33] zero
    output logic [mbrb_pkg::M_TDATA_W-1:0] m_tdata
);
    import mbrb_pkg::*;

    logic [11:0] dest_width;
    logic        fq_valid, fq_ready, qe_valid, qe_ready;
    cmd_t        fq_data, qe_data;

    mbrb_front u_front (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser, .dest_width,
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    mbrb_cmd_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
        .rd_valid(qe_valid), .rd_ready(qe_ready), .rd_data(qe_data)
    );

    mbrb_engine u_engine (
        .aclk, .aresetn, .dest_width,
        .q_valid(qe_valid), .q_ready(qe_ready), .q_data(qe_data),
        .m_tvalid, .m_tready, .m_tdata
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for mono_bitmap_rop_blitter_core: a directed table, then random loads,
// reads and blits, checked against a behavioral bitmap predictor here or typed expected results.
// Depends on mbrb_pkg and the blitter RTL.
module tb;
    import mbrb_pkg::*;

    localparam int LIMIT   = 4000000;
    localparam int N_ITEMS = 650;

    typedef struct {
        logic [1:0]  op;
        logic [13:0] addr;
        logic [7:0]  data;
        logic [11:0] pitch, sx, sy, x0, y0;
        logic [12:0] xe, ye;
        logic [3:0]  rop;
        bit          has_exp;
        logic [7:0]  exp_rd;
        logic [24:0] exp_pix;
    } req_t;

    typedef struct {
        logic [7:0]  rd;
        logic [24:0] pix;
    } res_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index = 1'b0;
    logic [11:0]          cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    mono_bitmap_rop_blitter_core dut (.*);

    // bitmap mirror and written-byte tracking
    logic [7:0]  src_bytes [MEM_BYTES];
    logic [7:0]  dst_bytes [MEM_BYTES];
    bit          src_ok [MEM_BYTES];
    bit          dst_ok [MEM_BYTES];
    logic [13:0] dst_written [$];
    int unsigned dest_w = 240, dest_h = 320;

    res_t pending_results [$];
    int   errors = 0;
    int   cycles = 0;
    int   sent = 0;
    int   rand_base = 0;
    bit   calm = 1'b0;
    int   stall_left = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // clipped end column and row of a blit
    function automatic void clip_rect(req_t r, output int unsigned xe, output int unsigned ye);
        xe = (r.xe > dest_w) ? dest_w : r.xe;
        ye = (r.ye > dest_h) ? dest_h : r.ye;
    endfunction

    // bitmap update and result for one accepted request
    function automatic res_t bitmap_step(req_t r);
        res_t o;
        int unsigned xe, ye, dp, sp, db, sb;
        logic s, d;
        o.rd = '0;
        o.pix = '0;
        case (r.op)
            OP_LOAD_SRC: begin
                src_bytes[r.addr] = r.data;
                src_ok[r.addr] = 1'b1;
            end
            OP_LOAD_DST: begin
                dst_bytes[r.addr] = r.data;
                if (!dst_ok[r.addr]) dst_written.push_back(r.addr);
                dst_ok[r.addr] = 1'b1;
            end
            OP_READ_DST: o.rd = dst_bytes[r.addr];
            default: begin
                clip_rect(r, xe, ye);
                if (r.x0 < xe && r.y0 < ye) begin
                    for (int unsigned cy = r.y0; cy < ye; cy++) begin
                        for (int unsigned cx = r.x0; cx < xe; cx++) begin
                            dp = cy * dest_w + cx;
                            sp = (r.sy + cy - r.y0) * r.pitch + r.sx + cx - r.x0;
                            db = (dp >> 3) % MEM_BYTES;
                            sb = (sp >> 3) % MEM_BYTES;
                            s = src_bytes[sb][sp & 7];
                            d = dst_bytes[db][dp & 7];
                            dst_bytes[db][dp & 7] = r.rop[3 - (2 * s + d)];
                        end
                    end
                    o.pix = 25'((xe - r.x0) * (ye - r.y0));
                end
            end
        endcase
        return o;
    endfunction

    // drive one request and log its expected result on acceptance
    task automatic send(req_t r);
        res_t o;
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {r.rop, r.ye, r.xe, r.y0, r.x0, r.sy, r.sx, r.pitch, r.data, r.addr};
        do @(posedge aclk); while (!s_tready);
        sent++;
        o = bitmap_step(r);
        if (r.has_exp) begin
            o.rd = r.exp_rd;
            o.pix = r.exp_pix;
        end
        pending_results.push_back(o);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    function automatic req_t plain(logic [1:0] op, logic [13:0] addr, logic [7:0] data);
        req_t r;
        r = '{default: '0};
        r.op = op;
        r.addr = addr;
        r.data = data;
        r.pitch = 12'($urandom);
        r.sx = 12'($urandom);
        r.sy = 12'($urandom);
        r.x0 = 12'($urandom);
        r.y0 = 12'($urandom);
        r.xe = 13'($urandom);
        r.ye = 13'($urandom);
        r.rop = 4'($urandom);
        return r;
    endfunction

    // load any byte a blit would read or keep that has never been written
    task automatic send_blit(req_t r);
        int unsigned xe, ye, dp, sp, db, sb;
        clip_rect(r, xe, ye);
        if (r.x0 < xe && r.y0 < ye) begin
            for (int unsigned cy = r.y0; cy < ye; cy++) begin
                for (int unsigned cx = r.x0; cx < xe; cx++) begin
                    dp = cy * dest_w + cx;
                    sp = (r.sy + cy - r.y0) * r.pitch + r.sx + cx - r.x0;
                    db = (dp >> 3) % MEM_BYTES;
                    sb = (sp >> 3) % MEM_BYTES;
                    if (!src_ok[sb]) send(plain(OP_LOAD_SRC, 14'(sb), 8'($urandom)));
                    if (!dst_ok[db]) send(plain(OP_LOAD_DST, 14'(db), 8'($urandom)));
                end
            end
        end
        send(r);
    endtask

    function automatic req_t blit(logic [11:0] pitch, logic [11:0] sx, logic [11:0] sy,
                                  logic [11:0] x0, logic [11:0] y0, logic [12:0] xe,
                                  logic [12:0] ye, logic [3:0] rop);
        req_t r;
        r = plain(OP_BLIT, 14'($urandom), 8'($urandom));
        r.pitch = pitch; r.sx = sx; r.sy = sy; r.x0 = x0; r.y0 = y0;
        r.xe = xe; r.ye = ye; r.rop = rop;
        return r;
    endfunction

    function automatic req_t typed(req_t r, logic [7:0] rd, logic [24:0] pix);
        r.has_exp = 1'b1;
        r.exp_rd = rd;
        r.exp_pix = pix;
        return r;
    endfunction

    // one random coordinate: near the clip limit, anywhere up to it, or anywhere in 12 bits
    function automatic logic [11:0] pick_start(int unsigned lim);
        int unsigned k;
        k = $urandom_range(0, 7);
        if (k == 0) return 12'($urandom);
        if (k < 3) return 12'(lim - $urandom_range(0, (lim < 10) ? lim : 10));
        return 12'($urandom_range(0, lim));
    endfunction

    function automatic logic [12:0] pick_end(logic [11:0] st);
        int unsigned k;
        k = $urandom_range(0, 7);
        if (k == 0) return 13'd4096;
        if (k == 1) return 13'($urandom);
        return 13'(st + $urandom_range(0, 14));
    endfunction

    task automatic random_item();
        req_t r;
        int unsigned xe, ye, k;
        k = $urandom_range(0, 9);
        if (k < 4) begin
            do begin
                r = blit(12'($urandom_range(1, 4095)), 12'($urandom), 12'($urandom),
                         pick_start(dest_w), pick_start(dest_h), '0, '0, 4'($urandom));
                if ($urandom_range(0, 15) == 0) r.pitch = 12'($urandom);
                r.xe = pick_end(r.x0);
                r.ye = pick_end(r.y0);
                clip_rect(r, xe, ye);
            end while (r.x0 < xe && r.y0 < ye && (xe - r.x0) * (ye - r.y0) > 300);
            send_blit(r);
        end else if (k < 7 || dst_written.size() == 0) begin
            send(plain((k < 5) ? OP_LOAD_SRC : OP_LOAD_DST, 14'($urandom), 8'($urandom)));
        end else begin
            send(plain(OP_READ_DST, dst_written[$urandom_range(0, dst_written.size() - 1)],
                       8'($urandom)));
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_DEST_WIDTH) dest_w = val;
        else dest_h = val;
    endtask

    // result checking and receiver stalls
    always @(posedge aclk) begin
        res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: read_data %0h pixels_done %0d",
                       m_tdata[7:0], m_tdata[32:8]);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_tdata[7:0] !== e.rd) begin
                    $error("read_data expected %0h actual %0h", e.rd, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[32:8] !== e.pix) begin
                    $error("pixels_done expected %0d actual %0d", e.pix, m_tdata[32:8]);
                    errors++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 15);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    req_t directed [$];
    int unsigned widths [6]  = '{240, 4095, 1, 13, 64, 0};
    int unsigned heights [6] = '{320, 4095, 1, 7, 40, 0};

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table: byte extremes, every raster op, empty and clipped blits
        directed.push_back(plain(OP_LOAD_DST, 14'd0, 8'hA5));
        directed.push_back(typed(plain(OP_READ_DST, 14'd0, 8'h00), 8'hA5, 25'd0));
        directed.push_back(plain(OP_LOAD_DST, 14'd16383, 8'h00));
        directed.push_back(typed(plain(OP_READ_DST, 14'd16383, 8'hFF), 8'h00, 25'd0));
        directed.push_back(plain(OP_LOAD_SRC, 14'd16383, 8'hFF));
        directed.push_back(plain(OP_LOAD_SRC, 14'd0, 8'h3C));
        for (int i = 0; i < 16; i++)
            directed.push_back(typed(blit(12'd8, 12'd0, 12'd0, 12'd0, 12'd0, 13'd8, 13'd1,
                                          4'(i)), 8'h00, 25'd8));
        directed.push_back(typed(blit(12'd8, 12'd0, 12'd0, 12'd5, 12'd0, 13'd5, 13'd1, 4'd6),
                                 8'h00, 25'd0));
        directed.push_back(typed(blit(12'd4095, 12'd4095, 12'd4095, 12'd236, 12'd319,
                                      13'd4096, 13'd4096, 4'd3), 8'h00, 25'd4));
        directed.push_back(plain(OP_READ_DST, 14'd0, 8'h00));
        foreach (directed[i]) begin
            if (directed[i].op == OP_BLIT) send_blit(directed[i]);
            else send(directed[i]);
        end
        wait_idle();

        // random phases over several geometry settings, sharing the item budget
        rand_base = sent;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                write_reg(CFG_DEST_WIDTH,
                          12'((ph == 5) ? $urandom_range(1, 300) : widths[ph]));
                write_reg(CFG_DEST_HEIGHT,
                          12'((ph == 5) ? $urandom_range(1, 300) : heights[ph]));
            end
            while (sent < rand_base + (ph + 1) * (N_ITEMS - rand_base) / 6) begin
                if (ph == 5 && sent > N_ITEMS - 30) calm = 1'b1;
                random_item();
            end
            wait_idle();
        end

        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mbrb_pkg.sv
hdl/mbrb_front.sv
hdl/mbrb_cmd_queue.sv
hdl/mbrb_engine.sv
hdl/mono_bitmap_rop_blitter_core.sv
tb/tb.sv
